// ===== hdl/rlzd_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rlzd_pkg: shared types and constants for the RLZ phrase bit decoder
// Command codes, default sizes and the controller/datapath handshake structs.
// ============================================================================
package rlzd_pkg;

    localparam int REF_BYTES_DEF       = 4096;
    localparam int MAX_PHRASE_BITS_DEF = 512;

    // Command codes carried in the input word's tuser
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_PHRASE = 2'd1;
    localparam logic [1:0] CMD_START  = 2'd2;

    // Controller -> datapath
    typedef struct packed {
        logic wr;        // write reference byte
        logic clear;     // drop held partial bits
        logic start;     // latch a phrase
        logic step;      // merge one reference byte
        logic emit_bad;  // load the rejected-phrase result
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic in_bad;      // incoming phrase is out of range or too long
        logic rem_zero;    // no phrase bits left
        logic byte_ready;  // current merge completes a byte
        logic final_step;  // current merge takes the last phrase bits
        logic out_free;    // output register can take a word this cycle
    } t_dp_stat;

endpackage

// ===== hdl/rlzd_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rlzd_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ============================================================================
module rlzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/rlzd_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rlzd_dp: decoder datapath
// Reference store, bit merge of one reference byte per step, partial-byte
// holding registers and the output word register.
// ============================================================================
module rlzd_dp #(
    parameter int REF_BYTES       = rlzd_pkg::REF_BYTES_DEF,
    parameter int MAX_PHRASE_BITS = rlzd_pkg::MAX_PHRASE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [11:0]        i_ref_addr,
    input  logic [7:0]         i_ref_byte,
    input  logic [14:0]        i_phrase_pos,
    input  logic [9:0]         i_phrase_len,
    input  rlzd_pkg::t_dp_cmd  i_cmd,
    output rlzd_pkg::t_dp_stat o_stat,
    input  logic               i_m_ready,
    output logic               o_m_valid,
    output logic [7:0]         o_m_byte,
    output logic               o_m_bad,
    output logic               o_m_last
);

    localparam int AW       = $clog2(REF_BYTES);
    localparam int REF_BITS = REF_BYTES * 8;
    localparam int BL_W     = $clog2((MAX_PHRASE_BITS + 7) / 8 + 1);

    // control state
    logic [6:0]      r_hold;
    logic [2:0]      r_cnt;
    logic [9:0]      r_rem;
    logic [BL_W-1:0] r_bytes_left;
    logic            r_out_valid;
    // payload
    logic [AW-1:0]   r_addr;
    logic [2:0]      r_off;
    logic [7:0]      r_out_byte;
    logic            r_out_bad;
    logic            r_out_last;

    logic [31:0]     w_waddr32;
    logic [31:0]     w_pos_byte32;
    logic            w_we;
    logic [AW-1:0]   w_raddr;
    logic [7:0]      w_q;
    logic [15:0]     w_end;
    logic [10:0]     w_tot_in;
    logic [3:0]      w_avail;
    logic [3:0]      w_k;
    logic [7:0]      w_shq;
    logic [7:0]      w_ext;
    logic [14:0]     w_comb;
    logic [14:0]     w_mask;
    logic [3:0]      w_tot;
    logic            w_final;
    logic            w_ready;
    logic            w_out_free;
    logic            w_emit;

    assign w_waddr32    = 32'(i_ref_addr);
    assign w_pos_byte32 = 32'(i_phrase_pos[14:3]);
    assign w_we         = i_cmd.wr && (w_waddr32 < 32'(REF_BYTES));

    // next address doubles as the RAM read address, so read data tracks r_addr
    always_comb begin
        if (i_cmd.start) begin
            w_raddr = w_pos_byte32[AW-1:0];
        end else if (i_cmd.step && !w_final) begin
            w_raddr = r_addr + AW'(1);
        end else begin
            w_raddr = r_addr;
        end
    end

    rlzd_ram #(
        .WIDTH (8),
        .DEPTH (REF_BYTES)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr32[AW-1:0]),
        .i_wdata (i_ref_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    // range check on the incoming phrase
    assign w_end    = 16'(i_phrase_pos) + 16'(i_phrase_len);
    assign w_tot_in = 11'(i_phrase_len) + 11'(r_cnt);

    // bit merge: take k bits of the current byte starting at r_off
    assign w_avail = 4'd8 - {1'b0, r_off};
    assign w_k     = (r_rem < 10'(w_avail)) ? r_rem[3:0] : w_avail;
    assign w_shq   = w_q << r_off;
    assign w_ext   = w_shq >> (4'd8 - w_k);
    assign w_comb  = (15'(r_hold) << w_k) | 15'(w_ext);
    assign w_tot   = {1'b0, r_cnt} + w_k;
    assign w_mask  = (15'd1 << w_tot[2:0]) - 15'd1;
    assign w_ready = w_tot[3];
    assign w_final = (r_rem == 10'(w_k));

    assign w_out_free = !r_out_valid || i_m_ready;
    assign w_emit     = i_cmd.step && w_ready;

    always_comb begin
        o_stat.in_bad     = (32'(i_phrase_len) > 32'(MAX_PHRASE_BITS))
                            || (32'(w_end) > 32'(REF_BITS));
        o_stat.rem_zero   = (r_rem == 10'd0);
        o_stat.byte_ready = w_ready;
        o_stat.final_step = w_final;
        o_stat.out_free   = w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold       <= '0;
            r_cnt        <= '0;
            r_rem        <= '0;
            r_bytes_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_hold <= '0;
                r_cnt  <= '0;
            end else if (i_cmd.step) begin
                r_hold <= w_ready ? 7'(w_comb & w_mask) : 7'(w_comb);
                r_cnt  <= w_tot[2:0];
            end
            if (i_cmd.start) begin
                r_rem        <= i_phrase_len;
                r_bytes_left <= BL_W'(w_tot_in >> 3);
            end else if (i_cmd.step) begin
                r_rem <= r_rem - 10'(w_k);
                if (w_ready) begin
                    r_bytes_left <= r_bytes_left - BL_W'(1);
                end
            end
            if (w_emit || i_cmd.emit_bad) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= w_raddr;
        if (i_cmd.start) begin
            r_off <= i_phrase_pos[2:0];
        end else if (i_cmd.step) begin
            r_off <= 3'd0;
        end
        if (w_emit) begin
            r_out_byte <= 8'(w_comb >> w_tot[2:0]);
            r_out_bad  <= 1'b0;
            r_out_last <= (r_bytes_left == BL_W'(1));
        end else if (i_cmd.emit_bad) begin
            r_out_byte <= 8'd0;
            r_out_bad  <= 1'b1;
            r_out_last <= 1'b1;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_byte  = r_out_byte;
    assign o_m_bad   = r_out_bad;
    assign o_m_last  = r_out_last;

`ifndef SYNTHESIS
    a_step_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> r_rem != 10'd0)
        else $error("merge step with no phrase bits left");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_out_free && r_bytes_left != '0)
        else $error("byte emitted without room or beyond expected count");

    a_count_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && w_final |=> r_bytes_left == '0)
        else $error("phrase ended with bytes still owed");
`endif

endmodule

// ===== hdl/rlzd_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rlzd_ctrl: decoder controller
// Accepts input words, decodes commands and sequences the datapath.
// ============================================================================
module rlzd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_command,
    output logic               o_ready,
    input  rlzd_pkg::t_dp_stat i_stat,
    output rlzd_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_BAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   w_accept;

    assign w_accept = i_valid && r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_command)
                        rlzd_pkg::CMD_LOAD: begin
                            o_cmd.wr = 1'b1;
                        end
                        rlzd_pkg::CMD_START: begin
                            o_cmd.clear = 1'b1;
                        end
                        rlzd_pkg::CMD_PHRASE: begin
                            o_cmd.start = 1'b1;
                            n_state     = i_stat.in_bad ? S_BAD : S_RUN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (i_stat.rem_zero) begin
                    n_state = S_IDLE;
                end else if (!i_stat.byte_ready || i_stat.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.final_step) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_BAD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_bad = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_ready = r_ready;

endmodule

// ===== hdl/rlz_phrase_bit_decoder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rlz_phrase_bit_decoder: bit-level relative Lempel-Ziv phrase decoder
// Loads a reference byte store and expands (bit position, length) phrases
// into a byte stream packed MSB first, carrying leftover bits across phrases.
// ============================================================================
//
// Channel  Dir  Bits   Content
// s_axis   in   48+2   tdata: ref_addr, ref_byte, phrase_pos, phrase_len;
//                      tuser: command
// m_axis   out  8+1+1  tdata: out_byte; tuser: bad_range; tlast: last
//
// Load and start words are accepted back to back. A phrase is accepted and then
// merged one reference byte per step (up to 65 bytes for 512 bits), since the
// single RAM read port delivers one reference byte per cycle while the merge
// is not stalled. The output register stalls the merge only when a finished
// word is still waiting. Reset clears the held partial bits and the control
// state; the reference store is not cleared and reads of unwritten bytes are
// undefined. s_axis_tready is low while a phrase is being expanded.
//
module rlz_phrase_bit_decoder #(
    parameter int REF_BYTES       = rlzd_pkg::REF_BYTES_DEF,
    parameter int MAX_PHRASE_BITS = rlzd_pkg::MAX_PHRASE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [11:0] ref_addr, [19:12] ref_byte,
                                        // [34:20] phrase_pos, [44:35] phrase_len
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tuser,   // [0] bad_range
    output logic        m_axis_tlast    // last word of a phrase
);

    rlzd_pkg::t_dp_cmd  w_cmd;
    rlzd_pkg::t_dp_stat w_stat;

    // Controller: owns the input handshake and walks the phrase, one merge
    // step per cycle unless the output register is holding a word.
    rlzd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_command (s_axis_tuser),
        .o_ready   (s_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    // Datapath: reference RAM, bit merge, partial-byte hold, output register.
    rlzd_dp #(
        .REF_BYTES       (REF_BYTES),
        .MAX_PHRASE_BITS (MAX_PHRASE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ref_addr   (s_axis_tdata[11:0]),
        .i_ref_byte   (s_axis_tdata[19:12]),
        .i_phrase_pos (s_axis_tdata[34:20]),
        .i_phrase_len (s_axis_tdata[44:35]),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_m_ready    (m_axis_tready),
        .o_m_valid    (m_axis_tvalid),
        .o_m_byte     (m_axis_tdata),
        .o_m_bad      (m_axis_tuser),
        .o_m_last     (m_axis_tlast)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for rlz_phrase_bit_decoder
// Drives load, phrase, start and unused-command words, keeps its own copy of
// the reference bytes and the held bits, and checks every output word in order.
// ============================================================================
module tb_top;

    localparam int    REF_BYTES       = rlzd_pkg::REF_BYTES_DEF;
    localparam int    MAX_PHRASE_BITS = rlzd_pkg::MAX_PHRASE_BITS_DEF;
    localparam int    REF_BITS        = REF_BYTES * 8;
    localparam int    TARGET_WORDS    = 420;
    localparam int    LONG_HOLD       = 300;   // receiver hold-off, cycles
    localparam int    DRAIN_LIMIT     = 200000;
    localparam int    TAIL_CYCLES     = 100;   // longer than the worst-case unstalled phrase
    localparam longint TIMEOUT_NS     = 80_000_000;

    // tuser code the block has no use for
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // input word tdata layout, lowest field at the bottom
    typedef struct packed {
        logic [2:0]  pad;
        logic [9:0]  len;
        logic [14:0] pos;
        logic [7:0]  val;
        logic [11:0] addr;
    } t_in_word;

    typedef struct packed {
        logic [7:0] data;
        logic       bad;
        logic       last;
    } t_out_word;

    // ------------------------------------------------------------------------
    // Expected-output tracker: mirrors the reference bytes and the held bits
    // ------------------------------------------------------------------------
    class phrase_predictor;
        logic [7:0] ref_copy [REF_BYTES];
        logic [6:0] held_bits;
        int         held_cnt;
        t_out_word  expected_bytes[$];
        int         mismatches;

        function new();
            held_bits  = '0;
            held_cnt   = 0;
            mismatches = 0;
            foreach (ref_copy[k]) ref_copy[k] = '0;
        endfunction

        // called once per accepted input word
        function void absorb_word(logic [1:0] cmd, logic [47:0] raw);
            t_in_word   w;
            t_out_word  r;
            logic [7:0] acc;
            logic [7:0] src;
            int         cnt;
            int         n;
            int         idx;
            w = t_in_word'(raw);
            case (cmd)
                rlzd_pkg::CMD_LOAD: begin
                    ref_copy[w.addr] = w.val;
                end
                rlzd_pkg::CMD_START: begin
                    held_bits = '0;
                    held_cnt  = 0;
                end
                rlzd_pkg::CMD_PHRASE: begin
                    if (int'(w.len) > MAX_PHRASE_BITS ||
                        int'(w.pos) + int'(w.len) > REF_BITS) begin
                        // rejected: one flagged word, held bits untouched
                        r = '{data: 8'h00, bad: 1'b1, last: 1'b1};
                        expected_bytes.push_back(r);
                    end else begin
                        acc = {1'b0, held_bits};
                        cnt = held_cnt;
                        n   = 0;
                        for (int i = 0; i < int'(w.len); i++) begin
                            idx = int'(w.pos) + i;
                            src = ref_copy[idx >> 3];
                            acc = {acc[6:0], src[7 - (idx & 7)]};
                            cnt++;
                            if (cnt == 8) begin
                                r = '{data: acc, bad: 1'b0, last: 1'b0};
                                expected_bytes.push_back(r);
                                n++;
                                acc = '0;
                                cnt = 0;
                            end
                        end
                        held_bits = acc[6:0];
                        held_cnt  = cnt;
                        if (n > 0) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        // called once per accepted output word
        function void check_word(logic [7:0] data, logic bad, logic last);
            t_out_word e;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected word data=%02h bad=%0b last=%0b",
                         $time, data, bad, last);
                mismatches++;
                return;
            end
            e = expected_bytes.pop_front();
            if (data !== e.data) begin
                $display("%0t: out_byte expected %02h actual %02h", $time, e.data, data);
                mismatches++;
            end
            if (bad !== e.bad) begin
                $display("%0t: bad_range expected %0b actual %0b", $time, e.bad, bad);
                mismatches++;
            end
            if (last !== e.last) begin
                $display("%0t: last expected %0b actual %0b", $time, e.last, last);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_bytes.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and clocking
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // [11:0] ref_addr, [19:12] ref_byte,
                                 // [34:20] phrase_pos, [44:35] phrase_len
    logic [1:0]  s_axis_tuser;   // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] out_byte
    logic        m_axis_tuser;   // [0] bad_range
    logic        m_axis_tlast;

    rlz_phrase_bit_decoder #(
        .REF_BYTES      (REF_BYTES),
        .MAX_PHRASE_BITS(MAX_PHRASE_BITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    phrase_predictor predictor = new();

    // reference bytes written so far; phrases only ever touch these
    bit ref_loaded [REF_BYTES];
    int loaded_addrs[$];

    int  words_sent   = 0;
    bit  tx_steady    = 1'b0;   // sender burst stretch: no gaps
    int  stall_request = 0;     // long receiver hold-off, set by the sender
    bit  rst_done     = 1'b0;
    bit  hold_done    = 1'b0;   // long receiver hold-off already asked for
    bit  pause_done   = 1'b0;   // sender drain pause already taken

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Present one word and hold it until accepted, then maybe idle a while.
    // tvalid stays high across back-to-back words, so it is lowered only in
    // the gap branch.
    task automatic send_word(input logic [1:0] cmd, input logic [47:0] data);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predictor.absorb_word(cmd, data);
        words_sent++;
        if ($urandom_range(63) == 0) tx_steady = !tx_steady;
        if (tx_steady) gap = 0;
        else if ($urandom_range(99) < 50) gap = 0;
        else if ($urandom_range(99) < 85) gap = $urandom_range(3, 1);
        else gap = $urandom_range(30, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic load_byte(input int addr, input logic [7:0] val, input logic [24:0] junk);
        t_in_word w;
        w = '{pad: 3'b0, len: junk[24:15], pos: junk[14:0], val: val, addr: addr[11:0]};
        send_word(rlzd_pkg::CMD_LOAD, w);
        if (!ref_loaded[addr]) begin
            ref_loaded[addr] = 1'b1;
            loaded_addrs.push_back(addr);
        end
    endtask

    task automatic send_phrase(input int pos, input int len);
        t_in_word w;
        w = '{pad: 3'b0, len: len[9:0], pos: pos[14:0],
              val: 8'($urandom), addr: 12'($urandom)};
        send_word(rlzd_pkg::CMD_PHRASE, w);
    endtask

    // make sure every byte an in-range phrase reads has been written
    task automatic fill_range(input int pos, input int len);
        if (len > 0) begin
            for (int a = pos >> 3; a <= (pos + len - 1) >> 3; a++)
                if (!ref_loaded[a]) load_byte(a, 8'($urandom), 25'($urandom));
        end
    endtask

    task automatic random_good_phrase();
        int len;
        int pos;
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)      len = $urandom_range(7, 0);
        else if (pick < 70) len = $urandom_range(40, 1);
        else if (pick < 90) len = $urandom_range(200, 41);
        else if (pick < 95) len = MAX_PHRASE_BITS;
        else                len = $urandom_range(MAX_PHRASE_BITS - 1, 201);
        // mostly start inside bytes already written, to keep loads few
        if ($urandom_range(3) != 0)
            pos = loaded_addrs[$urandom_range(loaded_addrs.size() - 1)] * 8
                  + $urandom_range(7);
        else
            pos = $urandom_range(REF_BITS - 1);
        if (pos + len > REF_BITS) pos = REF_BITS - len;
        fill_range(pos, len);
        send_phrase(pos, len);
    endtask

    task automatic random_bad_phrase();
        int len;
        if ($urandom_range(1) == 0) begin
            // too long, position anywhere
            send_phrase($urandom_range(REF_BITS - 1),
                        $urandom_range(1023, MAX_PHRASE_BITS + 1));
        end else begin
            // runs past the end of the reference
            len = $urandom_range(MAX_PHRASE_BITS, 2);
            send_phrase($urandom_range(REF_BITS - 1, REF_BITS - len + 1), len);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int pick;
        int base;
        int drain;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= rlzd_pkg::CMD_LOAD;
        s_axis_tdata  <= '0;
        i_rst_n       <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1'b1;

        // --- directed part ---
        load_byte(0, 8'hA5, 25'h0);
        load_byte(1, 8'h3C, 25'h0);
        load_byte(2, 8'hFF, 25'h0);
        load_byte(3, 8'h00, 25'h0);
        load_byte(REF_BYTES - 4, 8'h81, 25'h0);
        load_byte(REF_BYTES - 3, 8'h7E, 25'h0);
        load_byte(REF_BYTES - 2, 8'h55, 25'h0);
        load_byte(REF_BYTES - 1, 8'hFF, 25'h1FF_FFFF);      // junk fields all ones
        send_phrase(0, 0);                                   // empty phrase, no word
        send_phrase(0, 8);                                   // exactly one byte
        send_phrase(3, 5);                                   // completes nothing, 5 held
        send_phrase(9, 11);                                  // carry: 5 + 11 bits
        send_word(rlzd_pkg::CMD_START, 48'h0);               // drop held bits
        send_phrase(1, 7);                                   // 7 held
        send_phrase(REF_BITS - 31, 32);                      // past end, held kept
        send_phrase(8, 9);                                   // uses the 7 held bits
        send_phrase(0, MAX_PHRASE_BITS + 1);                 // too long
        send_word(CMD_UNUSED, 48'h1FFF_FFFF_FFFF);           // ignored
        send_phrase(REF_BITS - 1, 1023);                     // both fields at max
        send_phrase(REF_BITS - 32, 32);                      // ends on the last bit
        send_word(rlzd_pkg::CMD_START, 48'h0);
        send_phrase(REF_BITS - 8, 8);
        send_phrase(4, 20);

        // --- random part ---
        while (words_sent < TARGET_WORDS) begin
            if (!hold_done && words_sent >= 150) begin
                // hold the receiver off while phrases keep coming in
                stall_request = LONG_HOLD;
                hold_done     = 1'b1;
            end
            if (!pause_done && words_sent >= 300) begin
                // sender pause until the output side has drained
                pause_done = 1'b1;
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (predictor.outstanding() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(99);
            if (pick < 72) begin
                random_good_phrase();
            end else if (pick < 80) begin
                random_bad_phrase();
            end else if (pick < 91) begin
                base = $urandom_range(REF_BYTES - 1);
                for (int k = 0; k < $urandom_range(4, 1) && base + k < REF_BYTES; k++)
                    load_byte(base + k, 8'($urandom), 25'($urandom));
            end else if (pick < 97) begin
                send_word(rlzd_pkg::CMD_START,
                          48'({$urandom, $urandom} & 64'h1FFF_FFFF_FFFF));
            end else begin
                send_word(CMD_UNUSED, 48'({$urandom, $urandom} & 64'h1FFF_FFFF_FFFF));
            end
        end
        s_axis_tvalid <= 1'b0;

        // --- wind down ---
        drain = 0;
        while (predictor.outstanding() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (predictor.outstanding() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, predictor.outstanding());
            predictor.mismatches++;
        end
        if (predictor.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver side: random tready with short and long stalls, plus the one
    // long hold-off the sender asks for
    // ------------------------------------------------------------------------
    initial begin
        int  rx_hold;
        bit  rx_steady;
        rx_hold   = 0;
        rx_steady = 1'b0;
        m_axis_tready <= 1'b0;
        while (!rst_done) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                predictor.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (stall_request > 0) begin
                rx_hold       = stall_request;
                stall_request = 0;
            end
            if ($urandom_range(127) == 0) rx_steady = !rx_steady;
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end else if (!rx_steady && $urandom_range(99) < 4) begin
                m_axis_tready <= 1'b0;
                rx_hold = ($urandom_range(9) == 0) ? $urandom_range(30, 12) : $urandom_range(3, 1);
                rx_hold--;
            end else if (rx_steady) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(3) != 0);
            end
        end
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
